>>> sv/dd7seg_pkg.sv
// Shared constants and decode tables for the dual-digit seven-segment driver.
package dd7seg_pkg;

    localparam int unsigned ValueWidth = 8;
    localparam int unsigned TimeWidth = 32;
    localparam int unsigned FrameWidth = 16;
    localparam int unsigned PhaseWidth = 4;
    localparam int unsigned SegWidth = 7;
    localparam int unsigned InDataWidth = 40;
    localparam int unsigned OutDataWidth = 16;
    localparam int unsigned OutUsedWidth = 2 + SegWidth;

    localparam logic [FrameWidth-1:0] FrameTimeReset = 16'd500;
    localparam logic [PhaseWidth-1:0] SpinFrames = 4'd8;

    typedef logic [SegWidth-1:0] seg_t;

    // Segment pattern of one decimal digit, bit 0 = a through bit 6 = g.
    function automatic seg_t seg_font(input logic [3:0] digit);
        seg_t seg;
        begin
            unique case (digit)
                4'd0:    seg = 7'h3F;
                4'd1:    seg = 7'h06;
                4'd2:    seg = 7'h5B;
                4'd3:    seg = 7'h4F;
                4'd4:    seg = 7'h66;
                4'd5:    seg = 7'h6D;
                4'd6:    seg = 7'h7D;
                4'd7:    seg = 7'h07;
                4'd8:    seg = 7'h7F;
                4'd9:    seg = 7'h6F;
                default: seg = 7'h00;
            endcase
            return seg;
        end
    endfunction

    // Segment lit in each spinner frame.
    function automatic seg_t spin_seg(input logic [2:0] frame);
        seg_t seg;
        begin
            unique case (frame)
                3'd0: seg = 7'h01;
                3'd1: seg = 7'h02;
                3'd2: seg = 7'h04;
                3'd3: seg = 7'h08;
                3'd4: seg = 7'h08;
                3'd5: seg = 7'h10;
                3'd6: seg = 7'h20;
                3'd7: seg = 7'h01;
            endcase
            return seg;
        end
    endfunction

endpackage

>>> sv/dual_digit_seven_segment_mux.sv
// Top level of the dual-digit multiplexed seven-segment display driver.
//
//  Channel   Direction  Payload (lowest bit first)
//  s_*       in         display_value[7:0], now_ms[39:8]
//  m_*       out        digit_one_on[0], digit_two_on[1], segments[8:2], zeros[15:9]
//  cfg_*     in         frame_time_ms[15:0]
//
// One refresh beat per cycle when the output side keeps taking beats.
// A beat is captured in the input register, then the decode and the
// state update run in one pass into the output register.
// Both registers hold while the output register is full and m_tready is low; s_tready drops only when both are full.
// Synchronous active-low reset clears the drives, phase, frame time mark and
// sets the frame interval to 500 ms.
module dual_digit_seven_segment_mux (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dd7seg_pkg::InDataWidth-1:0]   s_tdata,  // display_value, now_ms
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dd7seg_pkg::OutDataWidth-1:0]  m_tdata,  // digit_one_on, digit_two_on, segments
    input  logic                                 cfg_we,
    input  logic [dd7seg_pkg::FrameWidth-1:0]    cfg_wdata
);
    import dd7seg_pkg::*;

    logic                    in_valid_reg;
    logic [ValueWidth-1:0]   in_value_reg;
    logic [TimeWidth-1:0]    in_now_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OutDataWidth-1:0] out_data_reg;

    logic [FrameWidth-1:0]   frame_time_reg;
    logic [PhaseWidth-1:0]   phase_reg;
    logic [PhaseWidth-1:0]   phase_next;
    logic [TimeWidth-1:0]    last_frame_reg;
    logic [TimeWidth-1:0]    last_frame_next;
    logic                    dig_one_reg;
    logic                    dig_one_next;
    logic                    dig_two_reg;
    logic                    dig_two_next;
    seg_t                    seg_reg;
    seg_t                    seg_next;

    logic                    advance;
    logic                    in_fire;
    logic [PhaseWidth-1:0]   phase_eff;
    logic [TimeWidth-1:0]    elapsed;
    logic [14:0]             div_prod;
    logic [3:0]              tens_quot;
    logic [3:0]              ones_digit;
    logic [3:0]              tens_digit;
    logic [ValueWidth-2:0]   mag;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // Divide by ten as (x * 205) >> 11, exact for the 7-bit magnitude.
    assign mag        = in_value_reg[ValueWidth-2:0];
    assign div_prod   = {8'd0, mag} * 15'd205;
    assign tens_quot  = div_prod[14:11];
    assign ones_digit = 4'(mag - 7'(tens_quot) * 7'd10);
    assign tens_digit = (tens_quot >= 4'd10) ? 4'(tens_quot - 4'd10) : tens_quot;
    assign elapsed    = in_now_reg - last_frame_reg;

    always_comb begin
        phase_next      = phase_reg;
        last_frame_next = last_frame_reg;
        dig_one_next    = dig_one_reg;
        dig_two_next    = dig_two_reg;
        seg_next        = seg_reg;
        phase_eff       = phase_reg;
        if (!in_value_reg[ValueWidth-1]) begin
            phase_eff = (phase_reg > 4'd1) ? 4'd0 : phase_reg;
            if (phase_eff == 4'd0) begin
                dig_one_next = 1'b1;
                dig_two_next = 1'b0;
                seg_next     = seg_font(ones_digit);
            end else begin
                dig_one_next = 1'b0;
                dig_two_next = 1'b1;
                seg_next     = seg_font(tens_digit);
            end
            phase_next = phase_eff + 4'd1;
        end else if (elapsed >= {{(TimeWidth-FrameWidth){1'b0}}, frame_time_reg}) begin
            phase_eff       = (phase_reg >= SpinFrames) ? 4'd0 : phase_reg;
            last_frame_next = in_now_reg;
            dig_one_next    = (phase_eff < 4'd4);
            dig_two_next    = !(phase_eff < 4'd4);
            seg_next        = spin_seg(phase_eff[2:0]);
            phase_next      = phase_eff + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            frame_time_reg <= FrameTimeReset;
            phase_reg      <= '0;
            last_frame_reg <= '0;
            dig_one_reg    <= 1'b0;
            dig_two_reg    <= 1'b0;
            seg_reg        <= '0;
        end else begin
            if (cfg_we) begin
                frame_time_reg <= cfg_wdata;
            end
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg      <= phase_next;
                last_frame_reg <= last_frame_next;
                dig_one_reg    <= dig_one_next;
                dig_two_reg    <= dig_two_next;
                seg_reg        <= seg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_value_reg <= s_tdata[ValueWidth-1:0];
            in_now_reg   <= s_tdata[ValueWidth+TimeWidth-1:ValueWidth];
        end
        if (advance) begin
            out_data_reg <= {{(OutDataWidth-OutUsedWidth){1'b0}},
                             seg_next, dig_two_next, dig_one_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> sv/dd7seg_checker.sv
// Port-level checker for the seven-segment driver, bound to the top level.
module dd7seg_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dd7seg_pkg::OutDataWidth-1:0] m_tdata
);
    import dd7seg_pkg::*;

    // A stalled result beat stays and keeps its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Exactly one digit is driven whenever any segment is lit, and never both.
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'b11) &&
                     ((m_tdata[OutUsedWidth-1:2] != '0) == (m_tdata[0] || m_tdata[1])))
        else $error("digit and segment drives disagree");

    // Padding bits above the segment field stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OutDataWidth-1:OutUsedWidth] == '0)
        else $error("padding bits of result beat are set");

endmodule

bind dual_digit_seven_segment_mux dd7seg_checker u_dd7seg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
